FILE: src/irdv_pkg.sv
// ----------------------------------------------------------------------------
// irdv_pkg: shared types and constants of the image reference digest validator
// Request and character-class structs, digest and port limits, prefix table.
// ----------------------------------------------------------------------------
package irdv_pkg;

	// digest: "sha256:" plus 64 hex digits
	localparam logic [6:0]  DIGEST_LEN      = 7'd71;
	localparam logic [6:0]  DIGEST_SAT      = 7'd72;
	localparam logic [6:0]  PREFIX_LEN      = 7'd7;
	localparam logic [2:0]  MAX_PORT_DIGITS = 3'd5;
	localparam logic [2:0]  PORT_DIGITS_SAT = 3'd6;
	localparam logic [16:0] MAX_PORT        = 17'd65535;

	// queue between front and back, power of two
	localparam int unsigned FIFO_DEPTH = 4;

	localparam logic FUNC_DIGEST = 1'b0;
	localparam logic FUNC_REF    = 1'b1;

	typedef struct packed {
		logic digit;   // 0-9
		logic lower;   // a-z
		logic hex;     // a-f
		logic punct;   // '.', '_' or '-'
		logic at;      // '@'
		logic slash;   // '/'
		logic colon;   // ':'
	} cls_t;

	typedef struct packed {
		logic       func;
		logic       last;
		logic [7:0] chr;
		cls_t       cls;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	function automatic logic [7:0] prefix_char(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0: c = 8'h73; // s
			3'd1: c = 8'h68; // h
			3'd2: c = 8'h61; // a
			3'd3: c = 8'h32; // 2
			3'd4: c = 8'h35; // 5
			3'd5: c = 8'h36; // 6
			3'd6: c = 8'h3a; // :
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

FILE: src/irdv_front.sv
// ----------------------------------------------------------------------------
// irdv_front: input side of the validator
// Takes requests from the slave stream, classifies the character and pushes
// the tagged request into the queue.
// ----------------------------------------------------------------------------
module irdv_front (
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,
	input  logic                s_tuser,
	input  logic                s_tlast,
	input  irdv_pkg::qstat_t    qstat,
	output logic                push,
	output irdv_pkg::item_t     item
);

	function automatic irdv_pkg::cls_t classify(input logic [7:0] c);
		irdv_pkg::cls_t k;
		k.digit = (c >= 8'h30) && (c <= 8'h39);
		k.lower = (c >= 8'h61) && (c <= 8'h7a);
		k.hex   = (c >= 8'h61) && (c <= 8'h66);
		k.punct = (c == 8'h2e) || (c == 8'h5f) || (c == 8'h2d);
		k.at    = (c == 8'h40);
		k.slash = (c == 8'h2f);
		k.colon = (c == 8'h3a);
		return k;
	endfunction

	assign s_tready = !qstat.full;
	assign push     = s_tvalid && !qstat.full;

	always_comb begin
		item.func = s_tuser;
		item.last = s_tlast;
		item.chr  = s_tdata;
		item.cls  = classify(s_tdata);
	end

endmodule

FILE: src/irdv_fifo.sv
// ----------------------------------------------------------------------------
// irdv_fifo: short request queue between front and back
// Lets the front keep taking requests while the back waits on its output.
// ----------------------------------------------------------------------------
module irdv_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  irdv_pkg::item_t     wr_item,
	input  logic                pop,
	output irdv_pkg::item_t     rd_item,
	output irdv_pkg::qstat_t    qstat
);

	localparam int unsigned PTR_W = $clog2(irdv_pkg::FIFO_DEPTH);
	localparam logic [PTR_W:0] DEPTH_CNT = (PTR_W + 1)'(irdv_pkg::FIFO_DEPTH);

	irdv_pkg::item_t  slot_q [irdv_pkg::FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign rd_item     = slot_q[rd_ptr_q];
	assign qstat.full  = (count_q == DEPTH_CNT);
	assign qstat.empty = (count_q == '0);

endmodule

FILE: src/irdv_back.sv
// ----------------------------------------------------------------------------
// irdv_back: parser, digest store and verdict output
// Stage one updates the digest and name checks and reads the stored digest,
// stage two compares the digest part and loads the output register.
// ----------------------------------------------------------------------------
module irdv_back #(
	parameter int unsigned MAX_REF_LEN = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  irdv_pkg::item_t     it,
	input  logic                head_vld,
	output logic                pop,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [7:0]          m_tdata
);

	localparam int unsigned RC_W = $clog2(MAX_REF_LEN + 2);
	localparam logic [RC_W-1:0] REF_MAX = RC_W'(MAX_REF_LEN);

	// parser state
	logic [6:0]      digest_count_q, digest_count_d;
	logic            digest_ok_q, digest_ok_d;
	logic [RC_W-1:0] ref_count_q, ref_count_d;
	logic            after_at_q, after_at_d;
	logic [6:0]      after_count_q, after_count_d;
	logic            ref_ok_q, ref_ok_d;
	logic            comp_nonempty_q, comp_nonempty_d;
	logic            prev_alnum_q, prev_alnum_d;
	logic            first_component_q, first_component_d;
	logic            colon_seen_q, colon_seen_d;
	logic            host_ok_q, host_ok_d;
	logic [2:0]      port_digits_q, port_digits_d;
	logic [16:0]     port_value_q, port_value_d;

	logic            mem_we;
	logic            cmp_en;
	logic            base_ok;
	logic            an;
	logic            adv;

	// stage two
	logic            vld_s2, res_s2, cmp_s2, base_s2;
	logic [7:0]      chr_s2, rd_s2;
	logic            mism_q;
	logic            mism_now;
	logic            out_vld_q, out_res_q;

	logic [7:0]      digest_mem [0:70];

	// stage two only holds when it carries a verdict the output cannot take
	assign adv = !(vld_s2 && res_s2 && out_vld_q && !m_tready);
	assign pop = head_vld && adv;
	assign an  = it.cls.lower || it.cls.digit;

	always_comb begin
		digest_count_d    = digest_count_q;
		digest_ok_d       = digest_ok_q;
		ref_count_d       = ref_count_q;
		after_at_d        = after_at_q;
		after_count_d     = after_count_q;
		ref_ok_d          = ref_ok_q;
		comp_nonempty_d   = comp_nonempty_q;
		prev_alnum_d      = prev_alnum_q;
		first_component_d = first_component_q;
		colon_seen_d      = colon_seen_q;
		host_ok_d         = host_ok_q;
		port_digits_d     = port_digits_q;
		port_value_d      = port_value_q;
		mem_we            = 1'b0;
		cmp_en            = 1'b0;
		base_ok           = 1'b0;

		if (pop && it.func == irdv_pkg::FUNC_DIGEST) begin
			if (digest_count_q < irdv_pkg::PREFIX_LEN) begin
				if (it.chr != irdv_pkg::prefix_char(digest_count_q[2:0])) begin
					digest_ok_d = 1'b0;
				end
			end else if (digest_count_q < irdv_pkg::DIGEST_LEN) begin
				if (!(it.cls.digit || it.cls.hex)) begin
					digest_ok_d = 1'b0;
				end
			end else begin
				digest_ok_d = 1'b0;
			end
			if (digest_count_q < irdv_pkg::DIGEST_LEN) begin
				mem_we         = 1'b1;
				digest_count_d = digest_count_q + 7'd1;
			end else begin
				digest_count_d = irdv_pkg::DIGEST_SAT;
			end
		end else if (pop) begin
			if (ref_count_q <= REF_MAX) begin
				ref_count_d = ref_count_q + 1'b1;
			end

			if (after_at_q) begin
				if (after_count_q < irdv_pkg::DIGEST_LEN) begin
					cmp_en        = 1'b1;
					after_count_d = after_count_q + 7'd1;
				end else begin
					after_count_d = irdv_pkg::DIGEST_SAT;
					ref_ok_d      = 1'b0;
				end
			end else if (it.cls.at) begin
				if (!comp_nonempty_q || !prev_alnum_q || colon_seen_q) begin
					ref_ok_d = 1'b0;
				end
				after_at_d = 1'b1;
			end else if (it.cls.slash) begin
				if (colon_seen_q) begin
					if (!host_ok_q || port_digits_q == 3'd0 ||
					    port_digits_q > irdv_pkg::MAX_PORT_DIGITS ||
					    port_value_q == 17'd0 || port_value_q > irdv_pkg::MAX_PORT) begin
						ref_ok_d = 1'b0;
					end
				end else if (!comp_nonempty_q || !prev_alnum_q) begin
					ref_ok_d = 1'b0;
				end
				first_component_d = 1'b0;
				comp_nonempty_d   = 1'b0;
				prev_alnum_d      = 1'b0;
				colon_seen_d      = 1'b0;
				host_ok_d         = 1'b1;
				port_digits_d     = 3'd0;
				port_value_d      = 17'd0;
			end else if (it.cls.colon) begin
				if (!first_component_q || colon_seen_q) begin
					ref_ok_d = 1'b0;
				end
				if (!comp_nonempty_q || !prev_alnum_q) begin
					host_ok_d = 1'b0;
				end
				colon_seen_d = 1'b1;
			end else if (colon_seen_q) begin
				if (!it.cls.digit) begin
					ref_ok_d = 1'b0;
				end else if (port_digits_q < irdv_pkg::MAX_PORT_DIGITS) begin
					// at most four digits so far, so times ten stays in range
					port_value_d  = (port_value_q << 3) + (port_value_q << 1)
					              + {13'd0, it.chr[3:0]};
					port_digits_d = port_digits_q + 3'd1;
				end else begin
					port_digits_d = irdv_pkg::PORT_DIGITS_SAT;
					ref_ok_d      = 1'b0;
				end
			end else begin
				if (!(an || it.cls.punct)) begin
					ref_ok_d = 1'b0;
				end
				if (!comp_nonempty_q && !an) begin
					ref_ok_d = 1'b0;
				end
				comp_nonempty_d = 1'b1;
				prev_alnum_d    = an;
			end

			if (it.last) begin
				// digest compare result joins in stage two
				base_ok = ref_ok_d && after_at_d &&
				          (after_count_d == irdv_pkg::DIGEST_LEN) &&
				          (ref_count_d <= REF_MAX) && digest_ok_q &&
				          (digest_count_q == irdv_pkg::DIGEST_LEN);
				digest_count_d    = 7'd0;
				digest_ok_d       = 1'b1;
				ref_count_d       = '0;
				after_at_d        = 1'b0;
				after_count_d     = 7'd0;
				ref_ok_d          = 1'b1;
				first_component_d = 1'b1;
				comp_nonempty_d   = 1'b0;
				prev_alnum_d      = 1'b0;
				colon_seen_d      = 1'b0;
				host_ok_d         = 1'b1;
				port_digits_d     = 3'd0;
				port_value_d      = 17'd0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			digest_mem[digest_count_q] <= it.chr;
		end
		if (pop && cmp_en) begin
			rd_s2 <= digest_mem[after_count_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digest_count_q    <= 7'd0;
			digest_ok_q       <= 1'b1;
			ref_count_q       <= '0;
			after_at_q        <= 1'b0;
			after_count_q     <= 7'd0;
			ref_ok_q          <= 1'b1;
			comp_nonempty_q   <= 1'b0;
			prev_alnum_q      <= 1'b0;
			first_component_q <= 1'b1;
			colon_seen_q      <= 1'b0;
			host_ok_q         <= 1'b1;
			port_digits_q     <= 3'd0;
			port_value_q      <= 17'd0;
		end else begin
			digest_count_q    <= digest_count_d;
			digest_ok_q       <= digest_ok_d;
			ref_count_q       <= ref_count_d;
			after_at_q        <= after_at_d;
			after_count_q     <= after_count_d;
			ref_ok_q          <= ref_ok_d;
			comp_nonempty_q   <= comp_nonempty_d;
			prev_alnum_q      <= prev_alnum_d;
			first_component_q <= first_component_d;
			colon_seen_q      <= colon_seen_d;
			host_ok_q         <= host_ok_d;
			port_digits_q     <= port_digits_d;
			port_value_q      <= port_value_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			chr_s2  <= it.chr;
			base_s2 <= base_ok;
		end
		if (vld_s2 && res_s2 && adv) begin
			out_res_q <= base_s2 && !mism_q && !mism_now;
		end
	end

	assign mism_now = cmp_s2 && (rd_s2 != chr_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2    <= 1'b0;
			res_s2    <= 1'b0;
			cmp_s2    <= 1'b0;
			mism_q    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (adv) begin
				vld_s2 <= pop;
				res_s2 <= pop && (it.func == irdv_pkg::FUNC_REF) && it.last;
				cmp_s2 <= pop && cmp_en;
			end
			if (vld_s2 && adv) begin
				if (res_s2) begin
					mism_q <= 1'b0;
				end else if (mism_now) begin
					mism_q <= 1'b1;
				end
			end
			if (vld_s2 && res_s2 && adv) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {7'd0, out_res_q};

endmodule

FILE: src/image_reference_digest_validator_core.sv
// ----------------------------------------------------------------------------
// image_reference_digest_validator_core: pinned image reference checker
// Stores a sha256 digest, then parses a reference stream and reports whether
// the name is well formed and the part after '@' equals the stored digest.
// ----------------------------------------------------------------------------
//  channel   dir  tdata            tuser           tlast
//  s_*       in   [7:0] char_byte  [0] func        last
//  m_*       out  [0] valid_res    -               -
//
// one request per cycle while s_tready is high; a verdict reaches m_tvalid once
// the last reference byte has passed the queue, the head parse and compare stage
// the digest store is a 71 x 8 memory with one write and one registered read
// s_tready drops only when the four-entry queue is full; the back stalls only
// while a verdict in the compare stage waits behind an unread one on m_*
// reset clears all control state; digest contents stay undefined until loaded
// ----------------------------------------------------------------------------
module image_reference_digest_validator_core #(
	parameter int unsigned MAX_REF_LEN = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] char_byte
	input  logic       s_tuser,   // [0] func
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata    // [0] valid_res, [7:1] zero
);

	irdv_pkg::qstat_t qstat;
	irdv_pkg::item_t  wr_item;
	irdv_pkg::item_t  rd_item;
	logic             push;
	logic             pop;

	irdv_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.qstat    (qstat),
		.push     (push),
		.item     (wr_item)
	);

	irdv_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (wr_item),
		.pop     (pop),
		.rd_item (rd_item),
		.qstat   (qstat)
	);

	irdv_back #(
		.MAX_REF_LEN (MAX_REF_LEN)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.it       (rd_item),
		.head_vld (!qstat.empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	a_pop_not_empty : assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("back popped an empty queue");

	a_full_holds : assert property (@(posedge clk) disable iff (!arst_n)
		qstat.full && !pop |=> qstat.full)
		else $error("queue lost an entry without a pop");

	a_push_lands : assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !qstat.empty || $past(pop))
		else $error("accepted request did not reach the queue");

	a_not_both : assert property (@(posedge clk) disable iff (!arst_n)
		!(qstat.full && qstat.empty))
		else $error("queue reports full and empty");

endmodule
